/* sv/mret_pkg.sv */
// Shared types and constants for the multi-rate moving average tracker.
package mret_pkg;

  localparam int unsigned MaxLanes  = 4;
  localparam int unsigned CountBits = 48;
  localparam int unsigned SumBits   = 64;
  localparam int unsigned RateBits  = 16;
  localparam int unsigned OutBits   = 32;
  localparam int unsigned UsedBits  = 3;
  localparam int unsigned IdxBits   = 3;

  localparam logic [IdxBits-1:0] RegRateA = 3'd0;
  localparam logic [IdxBits-1:0] RegRateB = 3'd1;
  localparam logic [IdxBits-1:0] RegRateC = 3'd2;
  localparam logic [IdxBits-1:0] RegRateD = 3'd3;
  localparam logic [IdxBits-1:0] RegUsed  = 3'd4;

  typedef enum logic [2:0] {
    StIdle,
    StAccum,
    StDivide,
    StLane,
    StReport
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic accum;
    logic div_start;
    logic div_step;
    logic lane_step;
    logic report;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic lane_last;
  } status_t;

endpackage

/* sv/mret_stream_if.sv */
// Valid and ready channel carrying one payload word.
interface mret_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/multi_rate_ema_tracker_top.sv */
// Top level of the multi-rate moving average tracker.
// Each input word is accumulated, divided and then applied to each lane in turn before its result word.
// A new word is taken only once the previous one is reported; the 64-step serial divider does most of the work.
// A result word left waiting stalls the next word only at its report step.
// Reset: count, sum and averages clear, all lanes warming, rates 6554, one lane in use.
module multi_rate_ema_tracker_top #(
  parameter int unsigned NumLanes     = 4,
  parameter int unsigned SampleBits   = 32,
  parameter int unsigned RateFracBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mret_pkg::IdxBits-1:0] cfg_idx_i,
  input  logic [mret_pkg::RateBits-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          avg_lane0_o,
  output logic signed [31:0]          avg_lane1_o,
  output logic signed [31:0]          avg_lane2_o,
  output logic signed [31:0]          avg_lane3_o,
  output logic signed [31:0]          smallest_avg_o,
  output logic signed [31:0]          largest_avg_o,
  output logic [3:0]                  warm_mask_o
);

  logic [mret_pkg::MaxLanes-1:0][mret_pkg::RateBits-1:0] rate_q;
  logic [mret_pkg::UsedBits-1:0] used_q;
  logic [mret_pkg::MaxLanes-1:0][mret_pkg::OutBits-1:0] avg;
  mret_pkg::cmd_t    cmd;
  mret_pkg::status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= {mret_pkg::MaxLanes{16'd6554}};
      used_q <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mret_pkg::RegRateA: rate_q[0] <= cfg_data_i;
        mret_pkg::RegRateB: rate_q[1] <= cfg_data_i;
        mret_pkg::RegRateC: rate_q[2] <= cfg_data_i;
        mret_pkg::RegRateD: rate_q[3] <= cfg_data_i;
        mret_pkg::RegUsed:  used_q    <= cfg_data_i[mret_pkg::UsedBits-1:0];
        default: ;
      endcase
    end
  end

  mret_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd)
  );

  mret_datapath #(
    .NumLanes(NumLanes), .SampleBits(SampleBits), .RateFracBits(RateFracBits)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .sample_i(sample_i),
    .rate_i(rate_q), .used_i(used_q), .avg_o(avg),
    .min_o(smallest_avg_o), .max_o(largest_avg_o), .mask_o(warm_mask_o)
  );

  assign avg_lane0_o = avg[0];
  assign avg_lane1_o = avg[1];
  assign avg_lane2_o = avg[2];
  assign avg_lane3_o = avg[3];

endmodule

/* sv/mret_ctrl.sv */
// Controller state machine sequencing accumulation, division and lane updates.
module mret_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mret_pkg::status_t status_i,
  output mret_pkg::cmd_t    cmd_o
);

  mret_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mret_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      mret_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mret_pkg::StAccum;
        end
      end
      mret_pkg::StAccum: begin
        cmd_o.accum     = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = mret_pkg::StDivide;
      end
      mret_pkg::StDivide: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = mret_pkg::StLane;
        end
      end
      mret_pkg::StLane: begin
        cmd_o.lane_step = 1'b1;
        if (status_i.lane_last) begin
          state_d = mret_pkg::StReport;
        end
      end
      mret_pkg::StReport: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.report = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = mret_pkg::StIdle;
        end
      end
      default: state_d = mret_pkg::StIdle;
    endcase
  end

endmodule

/* sv/mret_datapath.sv */
// Datapath: count, sum, serial divider, shared lane update unit and reporting.
module mret_datapath #(
  parameter int unsigned NumLanes     = 4,
  parameter int unsigned SampleBits   = 32,
  parameter int unsigned RateFracBits = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  mret_pkg::cmd_t                             cmd_i,
  output mret_pkg::status_t                          status_o,
  input  logic [SampleBits-1:0]                      sample_i,
  input  logic [mret_pkg::MaxLanes-1:0][mret_pkg::RateBits-1:0] rate_i,
  input  logic [mret_pkg::UsedBits-1:0]              used_i,
  output logic [mret_pkg::MaxLanes-1:0][mret_pkg::OutBits-1:0]  avg_o,
  output logic [mret_pkg::OutBits-1:0]               min_o,
  output logic [mret_pkg::OutBits-1:0]               max_o,
  output logic [mret_pkg::MaxLanes-1:0]              mask_o
);

  localparam int unsigned CB = mret_pkg::CountBits;
  localparam int unsigned SB = mret_pkg::SumBits;
  localparam int unsigned RB = mret_pkg::RateBits;
  localparam int unsigned OB = mret_pkg::OutBits;
  localparam int unsigned LaneW = (NumLanes > 1) ? $clog2(NumLanes) : 1;
  localparam int unsigned StepW = $clog2(SB + 1);
  localparam int unsigned DiffW = SampleBits + 1;
  localparam int unsigned ProdW = DiffW + RB + 1;
  localparam logic [CB-1:0] CountMax = {CB{1'b1}};
  localparam logic signed [SB:0] SmpMax = (SB + 1)'((65'sd1 <<< (SampleBits - 1)) - 1);
  localparam logic signed [SB:0] SmpMin = -SmpMax - 1;
  localparam logic [SB:0] MeanCap = $unsigned(SmpMax) + (SB + 1)'(1);
  localparam logic signed [SB:0] SumHi = (SB + 1)'({1'b0, {(SB - 1){1'b1}}});
  localparam logic signed [SB:0] SumLo = $signed({2'b11, {(SB - 1){1'b0}}});

  logic signed [SampleBits-1:0]  smp_q;
  logic [CB-1:0]                 count_q;
  logic signed [SB-1:0]          sum_q;
  logic [SB-1:0]                 quot_q, rem_q;
  logic [SB-1:0]                 dvd_q;
  logic                          neg_q;
  logic [StepW-1:0]              step_q;
  logic [LaneW-1:0]              lane_q;
  logic signed [SampleBits-1:0]  mean_q;
  logic signed [SampleBits-1:0]  avg_q [NumLanes];
  logic [NumLanes-1:0]           warming_q;

  // Saturating sum and count.
  logic signed [SB:0]   sum_ext;
  logic signed [SB-1:0] sum_sat;
  always_comb begin
    sum_ext = $signed({sum_q[SB-1], sum_q}) + (SB + 1)'(smp_q);
    if (sum_ext > SumHi) sum_sat = SumHi[SB-1:0];
    else if (sum_ext < SumLo) sum_sat = SumLo[SB-1:0];
    else sum_sat = sum_ext[SB-1:0];
  end

  // The divider sees the count and sum after this item's update.
  logic signed [SB-1:0] div_sum;
  always_comb begin
    div_sum = (count_q != CountMax) ? sum_sat : sum_q;
  end

  // One quotient bit a cycle, restoring.
  logic [SB:0] rem_sh;
  logic [SB:0] rem_sub;
  always_comb begin
    rem_sh  = {rem_q, dvd_q[SB-1]};
    rem_sub = rem_sh - (SB + 1)'(count_q);
  end

  assign status_o.div_last  = (step_q == StepW'(1));
  assign status_o.lane_last = (32'(lane_q) == NumLanes - 1);

  // Mean taken as the last quotient bit lands, clamped to the sample range.
  logic signed [SampleBits-1:0] mean_last;
  always_comb begin
    logic [SB:0]        q;
    logic signed [SB:0] m;
    q = {1'b0, quot_q[SB-2:0], !rem_sub[SB]};
    if (q > MeanCap) q = MeanCap;
    m = neg_q ? -$signed(q) : $signed(q);
    if (m > SmpMax) m = SmpMax;
    if (m < SmpMin) m = SmpMin;
    mean_last = SampleBits'(m);
  end

  // Shared lane update.
  logic [RB-1:0]                rate_cur;
  logic signed [SampleBits-1:0] avg_cur;
  logic [CB+RB-1:0]             cr_prod;
  logic                         leave;
  logic signed [DiffW-1:0]      diff;
  logic signed [ProdW-1:0]      prod;
  logic signed [ProdW-1:0]      stepv;
  logic signed [ProdW:0]        nxt;
  logic signed [SampleBits-1:0] nxt_c;
  always_comb begin
    rate_cur = rate_i[lane_q];
    avg_cur  = avg_q[lane_q];
    cr_prod  = count_q * rate_cur;
    leave    = warming_q[lane_q] &&
               (cr_prod > (CB + RB)'(1) << RateFracBits);
    diff     = DiffW'(smp_q) - DiffW'(avg_cur);
    prod     = ProdW'(diff) * $signed({1'b0, rate_cur});
    stepv    = prod >>> RateFracBits;
    nxt      = (ProdW + 1)'(avg_cur) + (ProdW + 1)'(stepv);
    if (nxt > (ProdW + 1)'(SmpMax)) nxt_c = SampleBits'(SmpMax);
    else if (nxt < (ProdW + 1)'(SmpMin)) nxt_c = SampleBits'(SmpMin);
    else nxt_c = SampleBits'(nxt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sum_q     <= '0;
      warming_q <= '1;
      step_q    <= '0;
      lane_q    <= '0;
      for (int i = 0; i < NumLanes; i++) avg_q[i] <= '0;
    end else begin
      if (cmd_i.accum && count_q != CountMax) begin
        count_q <= count_q + CB'(1);
        sum_q   <= sum_sat;
      end
      if (cmd_i.div_start) step_q <= StepW'(SB);
      else if (cmd_i.div_step) step_q <= step_q - StepW'(1);
      if (cmd_i.div_start) lane_q <= '0;
      else if (cmd_i.lane_step) begin
        if (leave) warming_q[lane_q] <= 1'b0;
        if (warming_q[lane_q] && !leave) avg_q[lane_q] <= mean_q;
        else avg_q[lane_q] <= nxt_c;
        if (!status_o.lane_last) lane_q <= lane_q + LaneW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) smp_q <= $signed(sample_i);
    if (cmd_i.div_start) begin
      neg_q  <= div_sum[SB-1];
      dvd_q  <= div_sum[SB-1] ? -div_sum : div_sum;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[SB-2:0], 1'b0};
      if (!rem_sub[SB]) begin
        rem_q  <= rem_sub[SB-1:0];
        quot_q <= {quot_q[SB-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[SB-1:0];
        quot_q <= {quot_q[SB-2:0], 1'b0};
      end
    end
    if (cmd_i.div_step && status_o.div_last) mean_q <= mean_last;
  end

  // Result registers.
  logic [mret_pkg::UsedBits-1:0] used;
  always_comb begin
    used = used_i;
    if (used == '0) used = mret_pkg::UsedBits'(1);
    if (32'(used) > NumLanes) used = mret_pkg::UsedBits'(NumLanes);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      logic signed [SampleBits-1:0] mn, mx, a;
      mn = avg_q[0];
      mx = mn;
      for (int i = 0; i < mret_pkg::MaxLanes; i++) begin
        if (i < NumLanes && 32'(used) > i) begin
          a = avg_q[i];
          avg_o[i]  <= OB'(a);
          mask_o[i] <= !warming_q[i];
          if (a < mn) mn = a;
          if (a > mx) mx = a;
        end else begin
          avg_o[i]  <= '0;
          mask_o[i] <= 1'b0;
        end
      end
      min_o <= OB'(mn);
      max_o <= OB'(mx);
    end
  end

endmodule

/* bench/tb_multi_rate_ema_tracker_top.sv */
// Self-checking bench for the multi-rate moving average tracker, with predictor and scoreboard.
module tb_multi_rate_ema_tracker_top;

  localparam longint          SmpMax   = 64'sd2147483647;
  localparam longint          SmpMin   = -64'sd2147483648;
  localparam longint          SumMax   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint          SumMin   = 64'h8000_0000_0000_0000;
  localparam longint unsigned CountMax = (64'd1 << mret_pkg::CountBits) - 64'd1;
  localparam longint unsigned RateOne  = 64'd1 << 16;
  localparam int              IdleLimit   = 3000;
  localparam int              HoldCycles  = 600;
  localparam int              HoldAtWord  = 120;

  typedef struct packed {
    logic signed [31:0] avg0;
    logic signed [31:0] avg1;
    logic signed [31:0] avg2;
    logic signed [31:0] avg3;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
    logic [3:0]         mask;
  } summary_t;

  logic clk;
  logic rst_ni;
  logic cfg_we;
  logic [mret_pkg::IdxBits-1:0]  cfg_idx;
  logic [mret_pkg::RateBits-1:0] cfg_data;

  mret_stream_if #(.payload_t(logic signed [31:0])) sample_ch ();
  mret_stream_if #(.payload_t(summary_t))           summary_ch ();

  multi_rate_ema_tracker_top u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (sample_ch.valid),
    .in_ready_o    (sample_ch.ready),
    .sample_i      (sample_ch.payload),
    .out_valid_o   (summary_ch.valid),
    .out_ready_i   (summary_ch.ready),
    .avg_lane0_o   (summary_ch.payload.avg0),
    .avg_lane1_o   (summary_ch.payload.avg1),
    .avg_lane2_o   (summary_ch.payload.avg2),
    .avg_lane3_o   (summary_ch.payload.avg3),
    .smallest_avg_o(summary_ch.payload.smallest),
    .largest_avg_o (summary_ch.payload.largest),
    .warm_mask_o   (summary_ch.payload.mask)
  );

  // Shadow of the block's registers and state.
  longint unsigned shadow_rate [mret_pkg::MaxLanes];
  longint unsigned shadow_used;
  longint unsigned shadow_count;
  longint          shadow_sum;
  longint          shadow_avg [mret_pkg::MaxLanes];
  bit              shadow_warming [mret_pkg::MaxLanes];

  logic signed [31:0] pending_samples [$];
  summary_t           expected_summaries [$];

  int  errors;
  int  words_in;
  int  words_out;
  int  send_wait;
  int  recv_wait;
  int  hold_cnt;
  int  idle_cycles;
  bit  no_gaps;
  bit  hold_done;

  function automatic longint clamp_sample(longint v);
    if (v > SmpMax) return SmpMax;
    if (v < SmpMin) return SmpMin;
    return v;
  endfunction

  function automatic summary_t fold_sample(logic signed [31:0] smp);
    longint          s;
    longint          mean;
    longint          mn;
    longint          mx;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned used;
    bit              neg;
    bit              upd;
    summary_t        r;
    s = longint'(smp);
    if (shadow_count < CountMax) begin
      shadow_count++;
      if (s > 0 && shadow_sum > SumMax - s) shadow_sum = SumMax;
      else if (s < 0 && shadow_sum < SumMin - s) shadow_sum = SumMin;
      else shadow_sum = shadow_sum + s;
    end
    neg = shadow_sum < 0;
    mag = neg ? (64'd0 - 64'(shadow_sum)) : 64'(shadow_sum);
    q = mag / shadow_count;
    if (q > 64'd2147483648) q = 64'd2147483648;
    mean = clamp_sample(neg ? -longint'(q - 64'd1) - 1 : longint'(q));
    for (int i = 0; i < mret_pkg::MaxLanes; i++) begin
      upd = !shadow_warming[i];
      if (shadow_warming[i]) begin
        if (shadow_count * shadow_rate[i] > RateOne) begin
          shadow_warming[i] = 1'b0;
          upd = 1'b1;
        end else begin
          shadow_avg[i] = mean;
        end
      end
      if (upd) begin
        shadow_avg[i] = clamp_sample(shadow_avg[i] +
                        (((s - shadow_avg[i]) * longint'(shadow_rate[i])) >>> 16));
      end
    end
    used = shadow_used;
    if (used == 0) used = 1;
    if (used > mret_pkg::MaxLanes) used = mret_pkg::MaxLanes;
    r = '0;
    mn = shadow_avg[0];
    mx = shadow_avg[0];
    for (int i = 0; i < mret_pkg::MaxLanes; i++) begin
      if (i < used) begin
        if (shadow_avg[i] < mn) mn = shadow_avg[i];
        if (shadow_avg[i] > mx) mx = shadow_avg[i];
        if (!shadow_warming[i]) r.mask[i] = 1'b1;
      end
    end
    r.avg0     = 32'(shadow_avg[0]);
    r.avg1     = (used > 1) ? 32'(shadow_avg[1]) : 32'sd0;
    r.avg2     = (used > 2) ? 32'(shadow_avg[2]) : 32'sd0;
    r.avg3     = (used > 3) ? 32'(shadow_avg[3]) : 32'sd0;
    r.smallest = 32'(mn);
    r.largest  = 32'(mx);
    return r;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: takes samples from the pending queue.
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_ch.valid   <= 1'b0;
      sample_ch.payload <= '0;
      send_wait = 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        expected_summaries.insert(expected_summaries.size(), fold_sample(sample_ch.payload));
        words_in++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          sample_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_ch.payload <= pending_samples.pop_front();
          sample_ch.valid   <= 1'b1;
          send_wait = no_gaps ? 0 : $urandom_range(0, 5);
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each result word and holds off once for a long stretch.
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      summary_ch.ready <= 1'b0;
      recv_wait = 0;
      hold_cnt  = 0;
    end else begin
      if (hold_cnt > 0) hold_cnt--;
      if (summary_ch.valid && summary_ch.ready) begin
        if (expected_summaries.size() == 0) begin
          $error("result word with no expectation waiting");
          errors++;
        end else begin
          summary_t e;
          e = expected_summaries.pop_front();
          check_field("avg_lane0", e.avg0, summary_ch.payload.avg0);
          check_field("avg_lane1", e.avg1, summary_ch.payload.avg1);
          check_field("avg_lane2", e.avg2, summary_ch.payload.avg2);
          check_field("avg_lane3", e.avg3, summary_ch.payload.avg3);
          check_field("smallest_avg", e.smallest, summary_ch.payload.smallest);
          check_field("largest_avg", e.largest, summary_ch.payload.largest);
          check_field("warm_mask", e.mask, summary_ch.payload.mask);
        end
        words_out++;
        recv_wait = no_gaps ? 0 : $urandom_range(0, 5);
        if (words_out == HoldAtWord && !hold_done) begin
          hold_cnt  = HoldCycles;
          hold_done = 1'b1;
        end
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      summary_ch.ready <= (recv_wait == 0 && hold_cnt == 0);
    end
  end

  always @(posedge clk) begin
    if (sample_ch.valid && sample_ch.ready || summary_ch.valid && summary_ch.ready || cfg_we ||
        pending_samples.size() == 0 && expected_summaries.size() == 0) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no word moved for %0d cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic drain();
    while (pending_samples.size() > 0 || sample_ch.valid || expected_summaries.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [mret_pkg::IdxBits-1:0] idx,
                           logic [mret_pkg::RateBits-1:0] data);
    cfg_idx  <= idx;
    cfg_data <= data;
    cfg_we   <= 1'b1;
    unique case (idx)
      mret_pkg::RegRateA: shadow_rate[0] = 64'(data);
      mret_pkg::RegRateB: shadow_rate[1] = 64'(data);
      mret_pkg::RegRateC: shadow_rate[2] = 64'(data);
      mret_pkg::RegRateD: shadow_rate[3] = 64'(data);
      mret_pkg::RegUsed:  shadow_used    = 64'(data[mret_pkg::UsedBits-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(int ra, int rb, int rc, int rd, int lanes);
    write_reg(mret_pkg::RegRateA, 16'(ra));
    write_reg(mret_pkg::RegRateB, 16'(rb));
    write_reg(mret_pkg::RegRateC, 16'(rc));
    write_reg(mret_pkg::RegRateD, 16'(rd));
    write_reg(mret_pkg::RegUsed, 16'(lanes));
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] draw_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $signed($urandom_range(0, 16'hFFFF)) - 32'sd32768;
      3: return $signed({16'($urandom_range(0, 16'hFFFF)), 16'h0000}) >>> 4;
      default: return $urandom;
    endcase
  endfunction

  int phase_rates [8][5];

  initial begin
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    errors = 0;
    words_in = 0;
    words_out = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    hold_done = 1'b0;
    for (int i = 0; i < mret_pkg::MaxLanes; i++) begin
      shadow_rate[i]    = 6554;
      shadow_avg[i]     = 0;
      shadow_warming[i] = 1'b1;
    end
    shadow_used  = 1;
    shadow_count = 0;
    shadow_sum   = 0;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    pending_samples = '{32'sd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, -32'sd1, 32'sd1, 32'h0001_0000, 32'hFFFF_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h5555_5555, 32'hAAAA_AAAA, 32'sd0, -32'sd1};
    drain();

    phase_rates[0] = '{65535, 65535, 65535, 65535, 4};
    phase_rates[1] = '{1, 1, 1, 1, 0};
    phase_rates[2] = '{1, 65535, 32768, 2, 7};
    phase_rates[3] = '{65535, 1, 6554, 65535, 2};
    phase_rates[4] = '{$urandom_range(1, 65535), $urandom_range(1, 65535),
                       $urandom_range(1, 65535), $urandom_range(1, 65535), 3};
    phase_rates[5] = '{21845, 43690, 256, 4096, 5};
    phase_rates[6] = '{$urandom_range(1, 65535), $urandom_range(1, 65535),
                       $urandom_range(1, 65535), $urandom_range(1, 65535), 1};
    phase_rates[7] = '{$urandom_range(1, 65535), 65535, 1, $urandom_range(1, 65535), 6};

    for (int p = 0; p < 8; p++) begin
      set_regs(phase_rates[p][0], phase_rates[p][1], phase_rates[p][2],
               phase_rates[p][3], phase_rates[p][4]);
      no_gaps = (p == 3 || p == 6);
      for (int n = 0; n < 92; n++) pending_samples.insert(pending_samples.size(), draw_sample());
      drain();
    end

    $display("Ran %0d sample words and checked %0d result words over eight register settings,",
             words_in, words_out);
    $display("covering rate extremes, every lane count and a long receiver hold-off.");
    if (errors == 0 && expected_summaries.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
